FILE: hw/rtl/mcss_pkg.sv
// ---------------------------------------------------------------------------
// mcss_pkg: shared definitions for the masked code signature scanner
// Constants, signature tables, the front-to-back event type and the back
// part's state type.
// ---------------------------------------------------------------------------
package mcss_pkg;

	localparam int MaxCandidates = 256;
	localparam int WindowWords   = 15;
	localparam int AddrW         = 64;
	localparam int WordW         = 32;
	localparam int CountOutW     = 9;
	localparam int PairW         = 16;
	localparam int FifoDepth     = 4;
	localparam int NumSigs       = 3;
	localparam logic [PairW-1:0] DistReset = 16'hAC;

	// Signature indices.
	localparam int SigXy   = 0;
	localparam int SigHot  = 1;
	localparam int SigPref = 2;

	localparam int SigLen [NumSigs] = '{4, 15, 11};

	// Start address offsets, in bytes back from the newest word.
	localparam logic [AddrW-1:0] XyBack   = 64'd12;
	localparam logic [AddrW-1:0] HotBack  = 64'd56;
	localparam logic [AddrW-1:0] PrefBack = 64'd40;

	localparam logic [WordW-1:0] SigVal [NumSigs][WindowWords] = '{
		'{32'hd10083ff, 32'ha9017bfd, 32'h910043fd, 32'hd00042c8, 32'h0, 32'h0, 32'h0,
		  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
		'{32'ha9bf7bfd, 32'h910003fd, 32'h90000008, 32'h91000108, 32'hc8dffd08,
		  32'hf100091f, 32'h54000121, 32'h90000008, 32'hf9400100, 32'h94000000,
		  32'h52800088, 32'h7100001f, 32'h1a881500, 32'ha8c17bfd, 32'hd65f03c0},
		'{32'hd10203ff, 32'ha9057bfd, 32'ha90657f6, 32'ha9074ff4, 32'h910143fd,
		  32'h90000008, 32'h91000108, 32'haa0103f3, 32'hc8dffd08, 32'haa0003f4,
		  32'hf100091f, 32'h0, 32'h0, 32'h0, 32'h0}
	};

	localparam logic [WordW-1:0] SigMsk [NumSigs][WindowWords] = '{
		'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h9f00001f, 32'h0, 32'h0, 32'h0,
		  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
		'{32'hffffffff, 32'hffffffff, 32'h9f00001f, 32'hffc003ff, 32'hffffffff,
		  32'hffffffff, 32'hffffffff, 32'h9f00001f, 32'hffc003ff, 32'hfc000000,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
		  32'h9f00001f, 32'hffc003ff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
		  32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0}
	};

	// Index 0 holds the newest word.
	typedef logic [WindowWords-1:0][WordW-1:0] window_t;

	typedef struct packed {
		logic             report;
		logic             xy;
		logic             hot;
		logic             pref;
		logic [AddrW-1:0] addr;
	} event_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_WALK,
		BK_FINISH
	} back_state_t;

	// Masked compare of one signature against the window. The oldest word of
	// the signature sits at window position length minus one.
	function automatic logic sig_match(window_t w, logic [3:0] fill, int s);
		logic       hit;
		logic [3:0] pos;
		hit = (fill >= 4'(SigLen[s]));
		for (int k = 0; k < WindowWords; k++) begin
			if (k < SigLen[s]) begin
				pos = 4'(SigLen[s] - 1 - k);
				if ((w[pos] & SigMsk[s][k]) != (SigVal[s][k] & SigMsk[s][k]))
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

FILE: hw/rtl/mcss_if.sv
// ---------------------------------------------------------------------------
// mcss_if: channel interfaces of the scanner
// Input item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface mcss_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] code_word;
	logic [63:0] word_address;
	logic        segment_start;
	modport source (output valid, kind, code_word, word_address, segment_start, input ready);
	modport sink (input valid, kind, code_word, word_address, segment_start, output ready);
endinterface

interface mcss_result_if;
	logic        valid;
	logic        ready;
	logic        safe;
	logic [8:0]  xy_count;
	logic [8:0]  hotseat_count;
	logic [8:0]  pref_count;
	logic [15:0] pair_total;
	logic [63:0] x_address;
	logic [63:0] y_address;
	logic [63:0] hotseat_address;
	logic [63:0] pref_address;
	logic        pref_found;
	logic        any_overflow;
	modport source (output valid, safe, xy_count, hotseat_count, pref_count, pair_total,
		x_address, y_address, hotseat_address, pref_address, pref_found, any_overflow,
		input ready);
	modport sink (input valid, safe, xy_count, hotseat_count, pref_count, pair_total,
		x_address, y_address, hotseat_address, pref_address, pref_found, any_overflow,
		output ready);
endinterface

interface mcss_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] pair_distance;
	modport source (output valid, pair_distance, input ready);
	modport sink (input valid, pair_distance, output ready);
endinterface

FILE: hw/rtl/masked_code_signature_scanner.sv
// ---------------------------------------------------------------------------
// masked_code_signature_scanner: masked multi-signature code scanner
// Scans a stream of code words for three masked signatures, pairs XY hits at
// a set distance and reports a verdict on request.
// ---------------------------------------------------------------------------
//
// Channel   Role    Transfer carries
// item      sink    kind, code_word, word_address, segment_start
// result    source  verdict, counts, pair and first-hit addresses
// cfg       sink    pair_distance
//
// A code word is taken every cycle while the event queue has room; the front
// classifies it in the cycle of its transfer.
// A hotseat or preference hit is recorded by the back while it stays idle; an
// XY hit with room in the hit store takes the back through its prepare, walk
// and finish states, the walk reading each stored XY hit through one read port.
// A report moves from the queue head to the output register once the back is
// idle and its register is free or taken, and waits while the result stalls.
// Reset returns the window, counts and flags to zero and pair_distance to 172;
// the hit store needs no clearing, as the fill count guards it.
// ---------------------------------------------------------------------------
module masked_code_signature_scanner #(
	parameter int MAX_CANDIDATES = mcss_pkg::MaxCandidates
) (
	input  logic          clk,
	input  logic          arst_n,
	mcss_item_if.sink     item,
	mcss_result_if.source result,
	mcss_cfg_if.sink      cfg
);
	// Pair distance register; to be written only while the block is idle, which the block itself does not enforce.
	logic [mcss_pkg::PairW-1:0] dist_q;

	// Front to queue, queue to back.
	mcss_pkg::event_t push_ev, pop_ev;
	logic             push, full, pop, empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dist_q <= mcss_pkg::DistReset;
		else if (cfg.valid)
			dist_q <= cfg.pair_distance;
	end

	// The front shifts every code word into the window, clears it on a report and queues hits and reports.
	mcss_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.ev     (push_ev),
		.full   (full)
	);

	// The queue lets the front keep taking words while the back walks.
	mcss_fifo #(.DEPTH(mcss_pkg::FifoDepth)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_ev  (push_ev),
		.full   (full),
		.pop    (pop),
		.rd_ev  (pop_ev),
		.empty  (empty)
	);

	// The back owns the hit sets, the pair walk and the report register.
	mcss_back #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_dist (dist_q),
		.ev        (pop_ev),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);
endmodule

FILE: hw/rtl/mcss_ram.sv
// ---------------------------------------------------------------------------
// mcss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mcss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/mcss_fifo.sv
// ---------------------------------------------------------------------------
// mcss_fifo: event queue between front and back
// A short first-in first-out queue of classified events.
// ---------------------------------------------------------------------------
module mcss_fifo #(
	parameter int DEPTH = mcss_pkg::FifoDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mcss_pkg::event_t wr_ev,
	output logic             full,
	input  logic             pop,
	output mcss_pkg::event_t rd_ev,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	mcss_pkg::event_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  cnt_q;

	assign full  = (cnt_q == CntW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_ev = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

FILE: hw/rtl/mcss_front.sv
// ---------------------------------------------------------------------------
// mcss_front: word window and signature classifier
// Shifts each code word into the window, matches the three signatures and
// queues an event for every hit or report.
// ---------------------------------------------------------------------------
module mcss_front (
	input  logic             clk,
	input  logic             arst_n,
	mcss_item_if.sink        item,
	output logic             push,
	output mcss_pkg::event_t ev,
	input  logic             full
);
	mcss_pkg::window_t win_q, base_win, next_win;
	logic [3:0]        fill_q, base_fill, next_fill;
	logic              take, hit_xy, hit_hot, hit_pref;

	assign item.ready = !full;
	assign take       = item.valid && !full;

	always_comb begin
		base_win  = item.segment_start ? '0 : win_q;
		base_fill = item.segment_start ? '0 : fill_q;
		next_win  = {base_win[mcss_pkg::WindowWords-2:0], item.code_word};
		next_fill = (base_fill == 4'(mcss_pkg::WindowWords)) ? base_fill : base_fill + 4'd1;
		hit_xy    = mcss_pkg::sig_match(next_win, next_fill, mcss_pkg::SigXy);
		hit_hot   = mcss_pkg::sig_match(next_win, next_fill, mcss_pkg::SigHot);
		hit_pref  = mcss_pkg::sig_match(next_win, next_fill, mcss_pkg::SigPref);
	end

	always_comb begin
		ev.report = item.kind;
		ev.xy     = !item.kind && hit_xy;
		ev.hot    = !item.kind && hit_hot;
		ev.pref   = !item.kind && hit_pref;
		ev.addr   = item.word_address;
		push      = take && (item.kind || hit_xy || hit_hot || hit_pref);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (take) begin
			if (item.kind) begin
				win_q  <= '0;
				fill_q <= '0;
			end else begin
				win_q  <= next_win;
				fill_q <= next_fill;
			end
		end
	end
endmodule

FILE: hw/rtl/mcss_back.sv
// ---------------------------------------------------------------------------
// mcss_back: hit sets, pair walk and report
// Records hits, walks the stored XY hits for pairs and builds the report.
// ---------------------------------------------------------------------------
module mcss_back #(
	parameter int MAX_CANDIDATES = mcss_pkg::MaxCandidates
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mcss_pkg::PairW-1:0]    pair_dist,
	input  mcss_pkg::event_t              ev,
	input  logic                          empty,
	output logic                          pop,
	mcss_result_if.source                 result
);
	localparam int CntW = $clog2(MAX_CANDIDATES + 1);
	localparam int IdxW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int AW   = mcss_pkg::AddrW;

	mcss_pkg::back_state_t state_q, state_d;

	logic [CntW-1:0]  xy_hits_q, hot_hits_q, pref_hits_q, rd_cnt_q;
	logic [AW-1:0]    first_hot_q, first_pref_q, pair_lo_q, pair_hi_q;
	logic [2:0]       ovf_q;
	logic [15:0]      pairs_q;
	logic [IdxW-1:0]  pli_q, lo_idx_q, cmp_idx_s1;
	logic [AW-1:0]    v_q, vp_q, vm_q;
	logic             vp_ok_q, vm_ok_q, up_q, lo_q, cmp_vld_s1;
	logic             rd_en, fin, xy_full, safe, pf, ovf;
	logic [AW-1:0]    rdata;
	logic [AW:0]      vp_sum, vm_diff;

	assign xy_full = (xy_hits_q >= CntW'(MAX_CANDIDATES));
	assign ovf     = (ovf_q != '0);
	assign safe    = !ovf && (pairs_q == 16'd1) && (hot_hits_q == CntW'(1));
	assign pf      = safe && (pref_hits_q == CntW'(1));
	assign vp_sum  = {1'b0, v_q} + {{(AW + 1 - mcss_pkg::PairW){1'b0}}, pair_dist};
	assign vm_diff = {1'b0, v_q} - {{(AW + 1 - mcss_pkg::PairW){1'b0}}, pair_dist};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcss_pkg::BK_IDLE:   if (pop && !ev.report && ev.xy && !xy_full)
				state_d = mcss_pkg::BK_PREP;
			mcss_pkg::BK_PREP:   state_d = mcss_pkg::BK_WALK;
			mcss_pkg::BK_WALK:   if (rd_cnt_q == xy_hits_q && !cmp_vld_s1)
				state_d = mcss_pkg::BK_FINISH;
			mcss_pkg::BK_FINISH: state_d = mcss_pkg::BK_IDLE;
			default:             state_d = mcss_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == mcss_pkg::BK_IDLE) && !empty &&
			(!ev.report || !result.valid || result.ready);
		rd_en = (state_q == mcss_pkg::BK_WALK) && (rd_cnt_q != xy_hits_q);
		fin   = (state_q == mcss_pkg::BK_FINISH);
	end

	mcss_ram #(.WIDTH(AW), .DEPTH(MAX_CANDIDATES)) u_store (
		.clk   (clk),
		.we    (fin),
		.waddr (xy_hits_q[IdxW-1:0]),
		.wdata (v_q),
		.re    (rd_en),
		.raddr (rd_cnt_q[IdxW-1:0]),
		.rdata (rdata)
	);

	// Payload registers of the walk and the report.
	always_ff @(posedge clk) begin
		if (pop && !ev.report && ev.xy)
			v_q <= ev.addr - mcss_pkg::XyBack;
		if (state_q == mcss_pkg::BK_PREP) begin
			vp_q    <= vp_sum[AW-1:0];
			vp_ok_q <= !vp_sum[AW] && (pair_dist != '0);
			vm_q    <= vm_diff[AW-1:0];
			vm_ok_q <= !vm_diff[AW] && (pair_dist != '0);
		end
		cmp_idx_s1 <= rd_cnt_q[IdxW-1:0];
		if (pop && ev.report) begin
			result.safe            <= safe;
			result.xy_count        <= mcss_pkg::CountOutW'(xy_hits_q);
			result.hotseat_count   <= mcss_pkg::CountOutW'(hot_hits_q);
			result.pref_count      <= mcss_pkg::CountOutW'(pref_hits_q);
			result.pair_total      <= pairs_q;
			result.x_address       <= safe ? pair_lo_q : '0;
			result.y_address       <= safe ? pair_hi_q : '0;
			result.hotseat_address <= safe ? first_hot_q : '0;
			result.pref_address    <= pf ? first_pref_q : '0;
			result.pref_found      <= pf;
			result.any_overflow    <= ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mcss_pkg::BK_IDLE;
			xy_hits_q    <= '0;
			hot_hits_q   <= '0;
			pref_hits_q  <= '0;
			first_hot_q  <= '0;
			first_pref_q <= '0;
			ovf_q        <= '0;
			pairs_q      <= '0;
			pair_lo_q    <= '0;
			pair_hi_q    <= '0;
			pli_q        <= '0;
			lo_idx_q     <= '0;
			rd_cnt_q     <= '0;
			up_q         <= 1'b0;
			lo_q         <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= rd_en;
			if (result.valid && result.ready && !(pop && ev.report))
				result.valid <= 1'b0;
			if (pop && ev.report) begin
				result.valid <= 1'b1;
				xy_hits_q    <= '0;
				hot_hits_q   <= '0;
				pref_hits_q  <= '0;
				first_hot_q  <= '0;
				first_pref_q <= '0;
				ovf_q        <= '0;
				pairs_q      <= '0;
				pair_lo_q    <= '0;
				pair_hi_q    <= '0;
				pli_q        <= '0;
			end else if (pop) begin
				if (ev.hot) begin
					if (hot_hits_q >= CntW'(MAX_CANDIDATES)) begin
						ovf_q[1] <= 1'b1;
					end else begin
						if (hot_hits_q == '0)
							first_hot_q <= ev.addr - mcss_pkg::HotBack;
						hot_hits_q <= hot_hits_q + 1'b1;
					end
				end
				if (ev.pref) begin
					if (pref_hits_q >= CntW'(MAX_CANDIDATES)) begin
						ovf_q[2] <= 1'b1;
					end else begin
						if (pref_hits_q == '0)
							first_pref_q <= ev.addr - mcss_pkg::PrefBack;
						pref_hits_q <= pref_hits_q + 1'b1;
					end
				end
				if (ev.xy) begin
					if (xy_full)
						ovf_q[0] <= 1'b1;
					rd_cnt_q <= '0;
					up_q     <= 1'b0;
					lo_q     <= 1'b0;
				end
			end
			if (rd_en)
				rd_cnt_q <= rd_cnt_q + 1'b1;
			// The two targets differ by twice the non-zero distance, so at most one of the
			// two compares fires in a cycle.
			if (cmp_vld_s1) begin
				if (vp_ok_q && rdata == vp_q) begin
					up_q <= 1'b1;
					if (pairs_q != 16'hFFFF)
						pairs_q <= pairs_q + 16'd1;
				end
				if (vm_ok_q && rdata == vm_q) begin
					lo_q     <= 1'b1;
					lo_idx_q <= cmp_idx_s1;
					if (pairs_q != 16'hFFFF)
						pairs_q <= pairs_q + 16'd1;
				end
			end
			if (fin) begin
				xy_hits_q <= xy_hits_q + 1'b1;
				if (up_q) begin
					pair_lo_q <= v_q;
					pair_hi_q <= vp_q;
					pli_q     <= xy_hits_q[IdxW-1:0];
				end else if (lo_q && (lo_idx_q >= pli_q || pair_lo_q == pair_hi_q)) begin
					pair_lo_q <= vm_q;
					pair_hi_q <= v_q;
					pli_q     <= lo_idx_q;
				end
			end
		end
	end
endmodule

FILE: hw/rtl/mcss_checker.sv
// ---------------------------------------------------------------------------
// mcss_checker: port-level checks of the scanner
// Checks the report fields against each other and the result handshake.
// ---------------------------------------------------------------------------
module mcss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        safe,
	input logic        pref_found,
	input logic        any_overflow,
	input logic [8:0]  hotseat_count,
	input logic [15:0] pair_total,
	input logic [63:0] x_address,
	input logic [63:0] y_address,
	input logic [63:0] hotseat_address
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn before transfer");

	a_pref_safe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pref_found |-> safe)
		else $error("preference found without a safe verdict");

	a_safe_terms: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && safe |-> !any_overflow && pair_total == 16'd1 && hotseat_count == 9'd1)
		else $error("safe verdict contradicts counts");

	a_unsafe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !safe |-> x_address == '0 && y_address == '0 && hotseat_address == '0)
		else $error("addresses shown on an unsafe verdict");
endmodule

bind masked_code_signature_scanner mcss_checker u_mcss_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.safe            (result.safe),
	.pref_found      (result.pref_found),
	.any_overflow    (result.any_overflow),
	.hotseat_count   (result.hotseat_count),
	.pair_total      (result.pair_total),
	.x_address       (result.x_address),
	.y_address       (result.y_address),
	.hotseat_address (result.hotseat_address)
);
